// ===== hdl/sne_pkg.sv =====
// Shared constants, codes, control structs and the sigmoid table for the
// sparse neuron network evaluator. No dependencies.
package sne_pkg;

   localparam int NEURONS          = 64;
   localparam int INPUT_NEURONS    = 8;
   localparam int OUTPUT_NEURONS   = 4;
   localparam int LINKS_PER_NEURON = 8;
   localparam int MAX_RESULTS      = 4;

   localparam int OUT_COUNT_A = (OUTPUT_NEURONS < NEURONS) ? OUTPUT_NEURONS : NEURONS;
   localparam int OUT_COUNT   = (OUT_COUNT_A < MAX_RESULTS) ? OUT_COUNT_A : MAX_RESULTS;

   localparam int OP_W        = 2;
   localparam int NEURON_W    = 6;
   localparam int SLOT_W      = 3;
   localparam int VALUE_W     = 16;
   localparam int SIG_W       = 13;
   localparam int OUT_SLOT_W  = 2;
   localparam int FRAC_W      = 12;
   localparam int LINK_DEPTH  = NEURONS * LINKS_PER_NEURON;
   localparam int LINK_ADDR_W = $clog2(LINK_DEPTH);
   localparam int LINK_CNT_W  = $clog2(LINKS_PER_NEURON);
   localparam int ACC_W       = 2 * VALUE_W + LINK_CNT_W + 1;
   localparam int SIG_IDX_W   = 8;
   localparam int SIG_DEPTH   = 1 << SIG_IDX_W;

   localparam logic [63:0] EXP_STEP = 64'd4034748382;

   typedef enum logic [OP_W-1:0] {
      OP_BIAS  = 2'd0,
      OP_LINK  = 2'd1,
      OP_INPUT = 2'd2,
      OP_EVAL  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_LINKS,
      ST_DRAIN,
      ST_OUT_ADDR,
      ST_OUT_SEND
   } state_type;

   typedef struct packed {
      logic                   bias_we;
      logic [NEURON_W-1:0]    bias_waddr;
      logic [VALUE_W-1:0]     bias_wdata;
      logic [NEURON_W-1:0]    bias_raddr;
      logic                   link_we;
      logic [LINK_ADDR_W-1:0] link_waddr;
      logic [NEURON_W-1:0]    link_wsrc;
      logic [VALUE_W-1:0]     link_wweight;
      logic [LINK_ADDR_W-1:0] link_raddr;
      logic                   value_we;
      logic [NEURON_W-1:0]    value_waddr;
      logic [VALUE_W-1:0]     value_wdata;
      logic [NEURON_W-1:0]    value_raddr;
   } store_ctl_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  bias;
      logic [NEURON_W-1:0] link_src;
      logic [VALUE_W-1:0]  link_weight;
      logic [VALUE_W-1:0]  value;
   } store_rd_type;

   typedef struct packed {
      logic acc_init;
      logic weight_en;
      logic mul_en;
      logic value_ok;
      logic acc_en;
   } mac_ctl_type;

   typedef logic [SIG_W-1:0] sig_table_type [SIG_DEPTH];

   function automatic sig_table_type build_sig_table();
      logic [127:0]   e;
      logic [127:0]   d;
      logic [127:0]   num;
      logic [127:0]   rem;
      logic [63:0]    quo;
      logic [SIG_W-1:0] pos [129];
      sig_table_type  tab;
      int             k;
      int             b;
      e = 128'd1 << 32;
      for (k = 0; k <= 128; k++) begin
         if (k > 0) begin
            e = (e * {64'd0, EXP_STEP} + (128'd1 << 31)) >> 32;
         end
         d   = (128'd1 << 32) + e;
         num = (128'd1 << 44) + (d >> 1);
         rem = '0;
         quo = '0;
         for (b = 63; b >= 0; b--) begin
            rem = (rem << 1) | {127'd0, num[b]};
            if (rem >= d) begin
               rem    = rem - d;
               quo[b] = 1'b1;
            end
         end
         pos[k] = quo[SIG_W-1:0];
      end
      for (k = 0; k < SIG_DEPTH; k++) begin
         if (k < SIG_DEPTH / 2) begin
            tab[k] = pos[k];
         end else begin
            tab[k] = SIG_W'(13'd4096 - pos[SIG_DEPTH - k]);
         end
      end
      return tab;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// ===== hdl/sparse_neuron_net_eval.sv =====
// Sparse recurrent network evaluator, top level.
// Depends on sne_pkg, sne_store, sne_mac and sne_seq.
//
// Usage:
//   req channel takes one item per handshake; req_tuser carries the op
//   (load bias, load link, write input neuron, evaluate).
//   Loads and input writes return nothing.
//   An evaluation walks neurons INPUT_NEURONS..NEURONS-1 through one shared
//   multiply-accumulate unit: for each neuron a setup step, then its links
//   in turn, then pipeline drain and write-back. Then 4 results leave on the
//   rsp channel, highest neuron first, the last one flagged by rsp_tlast.
//   req_tready is low from the evaluate item until the last result is taken.
//   A stalled result holds on rsp_tdata until rsp_tready rises.
//   After reset a clearing pass zeroes all stores with req_tready low.
module sparse_neuron_net_eval import sne_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // neuron_index, link_slot, source_index, value
   input  logic [1:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // output_slot, output_value
   output logic        rsp_tlast   // last
);

   store_ctl_type          st;
   store_rd_type           rd;
   mac_ctl_type            mac;
   logic [SIG_W-1:0]       sig;
   logic [OUT_SLOT_W-1:0]  rsp_slot;

   sne_store u_store (
      .clock (clock),
      .ctl   (st),
      .rd    (rd)
   );

   sne_mac u_mac (
      .clock  (clock),
      .ctl    (mac),
      .bias   (rd.bias),
      .weight (rd.link_weight),
      .value  (rd.value),
      .sig    (sig)
   );

   sne_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_neuron (req_tdata[5:0]),
      .req_slot   (req_tdata[8:6]),
      .req_source (req_tdata[14:9]),
      .req_value  (req_tdata[30:15]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_slot   (rsp_slot),
      .rsp_last   (rsp_tlast),
      .rd         (rd),
      .sig        (sig),
      .st         (st),
      .mac        (mac)
   );

   assign rsp_tdata = {1'b0, rd.value[SIG_W-1:0], rsp_slot};

endmodule

// ===== hdl/sne_store.sv =====
// Bias, link and neuron value memories, one write and one registered read each.
// Depends on sne_pkg.
module sne_store import sne_pkg::*; (
   input  logic          clock,
   input  store_ctl_type ctl,
   output store_rd_type  rd
);

   logic [VALUE_W-1:0]  bias_mem   [NEURONS];
   logic [VALUE_W-1:0]  value_mem  [NEURONS];
   logic [NEURON_W-1:0] src_mem    [LINK_DEPTH];
   logic [VALUE_W-1:0]  weight_mem [LINK_DEPTH];

   logic [VALUE_W-1:0]  bias_rd_ff;
   logic [VALUE_W-1:0]  value_rd_ff;
   logic [NEURON_W-1:0] src_rd_ff;
   logic [VALUE_W-1:0]  weight_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.bias_we) begin
         bias_mem[ctl.bias_waddr] <= ctl.bias_wdata;
      end
      bias_rd_ff <= bias_mem[ctl.bias_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.value_we) begin
         value_mem[ctl.value_waddr] <= ctl.value_wdata;
      end
      value_rd_ff <= value_mem[ctl.value_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.link_we) begin
         src_mem[ctl.link_waddr]    <= ctl.link_wsrc;
         weight_mem[ctl.link_waddr] <= ctl.link_wweight;
      end
      src_rd_ff    <= src_mem[ctl.link_raddr];
      weight_rd_ff <= weight_mem[ctl.link_raddr];
   end

   assign rd.bias        = bias_rd_ff;
   assign rd.value       = value_rd_ff;
   assign rd.link_src    = src_rd_ff;
   assign rd.link_weight = weight_rd_ff;

endmodule

// ===== hdl/sne_mac.sv =====
// Shared multiply-accumulate unit with Q4.12 saturation and sigmoid lookup.
// Depends on sne_pkg.
module sne_mac import sne_pkg::*; (
   input  logic               clock,
   input  mac_ctl_type        ctl,
   input  logic [VALUE_W-1:0] bias,
   input  logic [VALUE_W-1:0] weight,
   input  logic [VALUE_W-1:0] value,
   output logic [SIG_W-1:0]   sig
);

   logic signed [VALUE_W-1:0]   weight_ff;
   logic signed [2*VALUE_W-1:0] prod_ff;
   logic signed [2*VALUE_W-1:0] prod_in;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W-1:0]     acc_in;
   logic signed [VALUE_W-1:0]   value_eff;
   logic [ACC_W-FRAC_W-VALUE_W:0] acc_hi;
   logic                        fits;
   logic [VALUE_W-1:0]          sat;

   assign value_eff = ctl.value_ok ? $signed(value) : '0;
   assign prod_in   = value_eff * weight_ff;

   always_comb begin
      if (ctl.acc_init) begin
         acc_in = {{(ACC_W-VALUE_W-FRAC_W){bias[VALUE_W-1]}}, bias, {FRAC_W{1'b0}}};
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + {{(ACC_W-2*VALUE_W){prod_ff[2*VALUE_W-1]}}, prod_ff};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.weight_en) begin
         weight_ff <= $signed(weight);
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc_hi = acc_ff[ACC_W-1:FRAC_W+VALUE_W-1];
   assign fits   = (&acc_hi) | ~(|acc_hi);

   always_comb begin
      if (fits) begin
         sat = acc_ff[FRAC_W+VALUE_W-1:FRAC_W];
      end else if (acc_ff[ACC_W-1]) begin
         sat = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   assign sig = SIG_TABLE[sat[VALUE_W-1:VALUE_W-SIG_IDX_W]];

endmodule

// ===== hdl/sne_seq.sv =====
// Sequencer: memory clearing, item decode, per-link pipeline control and
// result walk. Depends on sne_pkg; drives sne_store and sne_mac.
module sne_seq import sne_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [NEURON_W-1:0]   req_neuron,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [NEURON_W-1:0]   req_source,
   input  logic [VALUE_W-1:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_SLOT_W-1:0] rsp_slot,
   output logic                  rsp_last,
   input  store_rd_type          rd,
   input  logic [SIG_W-1:0]      sig,
   output store_ctl_type         st,
   output mac_ctl_type           mac
);

   state_type              state_ff, state_in;
   logic [NEURON_W-1:0]    n_ff, n_in;
   logic [LINK_CNT_W-1:0]  j_ff, j_in;
   logic [OUT_SLOT_W-1:0]  k_ff, k_in;
   logic [LINK_ADDR_W-1:0] clr_ff, clr_in;
   logic                   v1_ff, v2_ff, v3_ff;
   logic                   src_ok_ff;
   logic                   issue;
   logic                   pipe_busy;
   logic                   clr_low;
   op_type                 op;

   assign op        = op_type'(req_op);
   assign pipe_busy = v1_ff | v2_ff | v3_ff;
   assign clr_low   = 32'(clr_ff) < NEURONS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         n_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         clr_ff   <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         clr_ff   <= clr_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         src_ok_ff <= 32'(rd.link_src) < NEURONS;
      end
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      clr_in    = clr_ff;
      issue     = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      st.bias_we      = 1'b0;
      st.bias_waddr   = req_neuron;
      st.bias_wdata   = req_value;
      st.bias_raddr   = n_ff;
      st.link_we      = 1'b0;
      st.link_waddr   = LINK_ADDR_W'(req_neuron) * LINK_ADDR_W'(LINKS_PER_NEURON)
                        + LINK_ADDR_W'(req_slot);
      st.link_wsrc    = req_source;
      st.link_wweight = req_value;
      st.link_raddr   = LINK_ADDR_W'(n_ff) * LINK_ADDR_W'(LINKS_PER_NEURON)
                        + LINK_ADDR_W'(j_ff);
      st.value_we     = 1'b0;
      st.value_waddr  = req_neuron;
      st.value_wdata  = req_value;
      st.value_raddr  = rd.link_src;

      case (state_ff)
         ST_CLEAR: begin
            st.bias_we      = clr_low;
            st.bias_waddr   = clr_ff[NEURON_W-1:0];
            st.bias_wdata   = '0;
            st.value_we     = clr_low;
            st.value_waddr  = clr_ff[NEURON_W-1:0];
            st.value_wdata  = '0;
            st.link_we      = 1'b1;
            st.link_waddr   = clr_ff;
            st.link_wsrc    = '0;
            st.link_wweight = '0;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == LINK_ADDR_W'(LINK_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (op)
                  OP_BIAS: begin
                     st.bias_we = 32'(req_neuron) < NEURONS;
                  end
                  OP_LINK: begin
                     st.link_we = (32'(req_neuron) < NEURONS)
                                  && (32'(req_slot) < LINKS_PER_NEURON);
                  end
                  OP_INPUT: begin
                     st.value_we = (32'(req_neuron) < NEURONS)
                                   && (32'(req_neuron) < INPUT_NEURONS);
                  end
                  OP_EVAL: begin
                     n_in     = NEURON_W'(INPUT_NEURONS);
                     j_in     = '0;
                     k_in     = '0;
                     state_in = ST_START;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_START: begin
            j_in     = '0;
            state_in = ST_LINKS;
         end
         ST_LINKS: begin
            issue = 1'b1;
            j_in  = j_ff + 1'b1;
            if (j_ff == LINK_CNT_W'(LINKS_PER_NEURON - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               st.value_we    = 1'b1;
               st.value_waddr = n_ff;
               st.value_wdata = VALUE_W'(sig);
               if (n_ff == NEURON_W'(NEURONS - 1)) begin
                  state_in = ST_OUT_ADDR;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_OUT_ADDR: begin
            st.value_raddr = NEURON_W'(NEURONS - 1) - NEURON_W'(k_ff);
            state_in       = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            st.value_raddr = NEURON_W'(NEURONS - 1) - NEURON_W'(k_ff);
            rsp_valid      = 1'b1;
            if (rsp_ready) begin
               if (k_ff == OUT_SLOT_W'(OUT_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_OUT_ADDR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_slot = k_ff;
   assign rsp_last = k_ff == OUT_SLOT_W'(OUT_COUNT - 1);

   assign mac.acc_init  = (state_ff == ST_LINKS) && (j_ff == '0);
   assign mac.weight_en = v1_ff;
   assign mac.mul_en    = v2_ff;
   assign mac.value_ok  = src_ok_ff;
   assign mac.acc_en    = v3_ff;

endmodule

// ===== hdl/sne_check.sv =====
// Port-level checker for sparse_neuron_net_eval, attached by bind.
// Depends on sne_pkg.
module sne_check import sne_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("req_tready high while a result is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_EVAL) |=> !req_tready)
      else $error("ready right after an evaluate item");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[1:0] == 2'(OUT_COUNT - 1))))
      else $error("tlast does not match final output slot");

   a_sig_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:2] <= 13'd4096) && !rsp_tdata[15])
      else $error("output value outside sigmoid range");

endmodule

bind sparse_neuron_net_eval sne_check u_check (.*);

// ===== tb/tb_sparse_neuron_net_eval.sv =====
`timescale 1ns / 1ps
// Testbench for sparse_neuron_net_eval: directed and random load, input-write and evaluate
// items checked against a shadow network kept here. Depends on sne_pkg and the RTL.
module tb_sparse_neuron_net_eval;
   import sne_pkg::*;

   localparam int DRAIN_CYCLES = 800;
   localparam int LONG_HOLD    = 1500;
   localparam longint unsigned EXP_DECAY = 64'd4034748382;

   typedef struct packed {
      logic [1:0]  slot;
      logic [12:0] level;
      logic        last;
   } net_output_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // neuron_index, link_slot, source_index, value
   logic [1:0]  req_tuser = '0;  // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // output_slot, output_value
   logic        rsp_tlast;       // last

   logic [15:0] shadow_value  [NEURONS]    = '{default: '0};
   logic [15:0] shadow_bias   [NEURONS]    = '{default: '0};
   logic [5:0]  shadow_src    [LINK_DEPTH] = '{default: '0};
   logic [15:0] shadow_weight [LINK_DEPTH] = '{default: '0};
   logic [12:0] sigmoid_lut   [256];

   net_output_type pending_outputs [$];
   net_output_type seen_output;
   net_output_type due_output;
   int          error_count = 0;
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   bit          rsp_hold_request = 1'b0;

   sparse_neuron_net_eval u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic void build_sigmoid_lut();
      longint unsigned decay;
      longint unsigned den;
      logic [12:0]     pos_side [129];
      int              k;
      decay = 64'd1 << 32;
      for (k = 0; k <= 128; k++) begin
         if (k > 0) begin
            decay = (decay * EXP_DECAY + (64'd1 << 31)) >> 32;
         end
         den = (64'd1 << 32) + decay;
         pos_side[k] = 13'(((64'd1 << 44) + den / 2) / den);
      end
      for (k = 0; k < 256; k++) begin
         if (k < 128) begin
            sigmoid_lut[k] = pos_side[k];
         end else begin
            sigmoid_lut[k] = 13'(13'd4096 - pos_side[256 - k]);
         end
      end
   endfunction

   function automatic logic [15:0] neuron_response(int n);
      longint      acc;
      logic [15:0] sat;
      int          j;
      int          base;
      base = n * LINKS_PER_NEURON;
      acc  = longint'($signed(shadow_bias[n])) * 4096;
      for (j = 0; j < LINKS_PER_NEURON; j++) begin
         acc += longint'($signed(shadow_value[shadow_src[base + j]]))
              * longint'($signed(shadow_weight[base + j]));
      end
      acc = acc >>> 12;
      if (acc > 32767) begin
         sat = 16'h7fff;
      end else if (acc < -32768) begin
         sat = 16'h8000;
      end else begin
         sat = acc[15:0];
      end
      return {3'b000, sigmoid_lut[sat[15:8]]};
   endfunction

   function automatic void apply_item(op_type op, logic [5:0] ni, logic [2:0] slot,
                                      logic [5:0] src, logic [15:0] value);
      net_output_type outp;
      int          n;
      int          k;
      case (op)
         OP_BIAS: begin
            shadow_bias[ni] = value;
         end
         OP_LINK: begin
            shadow_src[ni * LINKS_PER_NEURON + slot]    = src;
            shadow_weight[ni * LINKS_PER_NEURON + slot] = value;
         end
         OP_INPUT: begin
            if (ni < INPUT_NEURONS) begin
               shadow_value[ni] = value;
            end
         end
         OP_EVAL: begin
            for (n = INPUT_NEURONS; n < NEURONS; n++) begin
               shadow_value[n] = neuron_response(n);
            end
            for (k = 0; k < OUT_COUNT; k++) begin
               outp.slot  = 2'(k);
               outp.level = shadow_value[NEURONS - 1 - k][12:0];
               outp.last  = (k == OUT_COUNT - 1);
               pending_outputs = {pending_outputs, outp};
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_item(op_type op, logic [5:0] ni, logic [2:0] slot,
                            logic [5:0] src, logic [15:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, value, src, slot, ni};
      do @(posedge clock); while (req_tready !== 1'b1);
      apply_item(op, ni, slot, src, value);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_q412();
      case ($urandom_range(0, 4))
         0:       return 16'($urandom);
         1:       return 16'(int'($urandom_range(0, 2048)) - 1024);
         2:       return 16'(int'($urandom_range(0, 16384)) - 8192);
         3: begin
            case ($urandom_range(0, 3))
               0:       return 16'h7fff;
               1:       return 16'h8000;
               2:       return 16'hffff;
               default: return 16'h0000;
            endcase
         end
         default: return 16'(int'($urandom_range(0, 512)) - 256);
      endcase
   endfunction

   function automatic logic [5:0] pick_eval_neuron();
      if ($urandom_range(0, 1) == 0) begin
         return 6'($urandom_range(NEURONS - 8, NEURONS - 1));
      end
      return 6'($urandom_range(INPUT_NEURONS, NEURONS - 1));
   endfunction

   function automatic logic [5:0] pick_source();
      if ($urandom_range(0, 1) == 0) begin
         return 6'($urandom_range(0, INPUT_NEURONS - 1));
      end
      return 6'($urandom_range(0, NEURONS - 1));
   endfunction

   task automatic test_reset_state();
      send_item(OP_EVAL, 6'd0, 3'd0, 6'd0, 16'h0000);
      wait_for_results();
   endtask

   task automatic test_field_extremes();
      send_item(OP_BIAS,  6'd63, 3'd0, 6'd0,  16'h7fff);
      send_item(OP_BIAS,  6'd62, 3'd0, 6'd0,  16'h8000);
      send_item(OP_BIAS,  6'd0,  3'd0, 6'd0,  16'h1234);
      send_item(OP_LINK,  6'd61, 3'd0, 6'd0,  16'h8000);
      send_item(OP_LINK,  6'd61, 3'd7, 6'd63, 16'h7fff);
      send_item(OP_LINK,  6'd60, 3'd3, 6'd61, 16'h1000);
      send_item(OP_LINK,  6'd62, 3'd5, 6'd60, 16'h1000);
      send_item(OP_INPUT, 6'd0,  3'd0, 6'd0,  16'h7fff);
      send_item(OP_INPUT, 6'd7,  3'd0, 6'd0,  16'h8000);
      send_item(OP_INPUT, 6'd8,  3'd0, 6'd0,  16'h4000);
      send_item(OP_INPUT, 6'd63, 3'd7, 6'd63, 16'hffff);
      send_item(OP_EVAL,  6'd0,  3'd0, 6'd0,  16'h0000);
      send_item(OP_EVAL,  6'd63, 3'd7, 6'd63, 16'hffff);
      send_item(OP_LINK,  6'd63, 3'd2, 6'd7,  16'h8000);
      send_item(OP_BIAS,  6'd63, 3'd0, 6'd0,  16'h0000);
      send_item(OP_INPUT, 6'd7,  3'd0, 6'd0,  16'h0800);
      send_item(OP_EVAL,  6'd0,  3'd0, 6'd0,  16'h0000);
      wait_for_results();
   endtask

   task automatic test_result_backpressure();
      rsp_hold_request = 1'b1;
      send_item(OP_EVAL, 6'd0, 3'd0, 6'd0, 16'h0000);
      send_item(OP_INPUT, 6'd3, 3'd0, 6'd0, rand_q412());
      send_item(OP_BIAS, pick_eval_neuron(), 3'd0, 6'd0, rand_q412());
      send_item(OP_EVAL, 6'd0, 3'd0, 6'd0, 16'h0000);
      wait_for_results();
   endtask

   task automatic test_sender_pause();
      send_item(OP_LINK, 6'd63, 3'($urandom_range(0, 7)), pick_source(), rand_q412());
      send_item(OP_EVAL, 6'd0, 3'd0, 6'd0, 16'h0000);
      wait_for_results();
      send_item(OP_INPUT, 6'($urandom_range(0, 7)), 3'd0, 6'd0, rand_q412());
      send_item(OP_EVAL, 6'd0, 3'd0, 6'd0, 16'h0000);
      wait_for_results();
   endtask

   task automatic run_program(int loads, ref int sent);
      int i;
      for (i = 0; i < loads; i++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               send_item(OP_BIAS, pick_eval_neuron(), 3'($urandom), 6'($urandom), rand_q412());
               sent++;
            end
            2, 3, 4, 5: begin
               send_item(OP_LINK, pick_eval_neuron(), 3'($urandom_range(0, 7)), pick_source(),
                         rand_q412());
               sent++;
            end
            6, 7, 8: begin
               send_item(OP_INPUT, 6'($urandom_range(0, INPUT_NEURONS - 1)), 3'($urandom),
                         6'($urandom), rand_q412());
               sent++;
            end
            default: begin
               send_item(OP_INPUT, 6'($urandom_range(INPUT_NEURONS, NEURONS - 1)),
                         3'($urandom), 6'($urandom), 16'($urandom));
            end
         endcase
      end
      send_item(OP_EVAL, 6'($urandom), 3'($urandom), 6'($urandom), 16'($urandom));
      sent++;
   endtask

   task automatic test_random_programs();
      int sent;
      sent = 0;
      while (sent < 200) begin
         run_program($urandom_range(0, 7), sent);
         if ($urandom_range(0, 7) == 0) begin
            wait_for_results();
         end
      end
      wait_for_results();
   endtask

   task automatic test_steady_stream();
      int sent;
      sent = 0;
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      while (sent < 30) begin
         run_program($urandom_range(2, 6), sent);
      end
      wait_for_results();
   endtask

   initial begin
      int hold_count;
      @(posedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         seen_output.slot  = rsp_tdata[1:0];
         seen_output.level = rsp_tdata[14:2];
         seen_output.last  = rsp_tlast;
         if (pending_outputs.size() == 0) begin
            $display("%0t: expected no output, actual slot %0d value %0d last %0b", $time,
                     seen_output.slot, seen_output.level, seen_output.last);
            error_count++;
         end else begin
            due_output = pending_outputs.pop_front();
            if (seen_output.slot !== due_output.slot || seen_output.level !== due_output.level
                || seen_output.last !== due_output.last) begin
               $display("%0t: expected slot %0d value %0d last %0b, actual %0d %0d %0b",
                        $time, due_output.slot, due_output.level, due_output.last,
                        seen_output.slot, seen_output.level, seen_output.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      build_sigmoid_lut();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_field_extremes();
      test_result_backpressure();
      test_sender_pause();
      test_random_programs();
      test_steady_stream();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outputs.size() != 0) begin
         $display("%0t: %0d outputs never arrived", $time, pending_outputs.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
